@@ hw/rtl/printable_string_finder_defines.svh @@
// Assertion macros shared by the RTL.
`ifndef PRINTABLE_STRING_FINDER_DEFINES_SVH
`define PRINTABLE_STRING_FINDER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define PSF_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define PSF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/psf_pkg.sv @@
package psf_pkg;

  localparam int OFFSET_BITS_DEFAULT = 32;
  localparam int LENGTH_BITS_DEFAULT = 16;
  localparam int QUEUE_DEPTH_DEFAULT = 4;

  localparam logic [7:0] MIN_LENGTH_RESET = 8'd4;
  localparam logic [7:0] PRINT_LO = 8'h20;
  localparam logic [7:0] PRINT_HI = 8'h7E;
  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;

  localparam logic [2:0] END_NUL = 3'd0;
  localparam logic [2:0] END_LF = 3'd1;
  localparam logic [2:0] END_CR = 3'd2;
  localparam logic [2:0] END_LFCR = 3'd3;
  localparam logic [2:0] END_CRLF = 3'd4;

  localparam logic KIND_STRING = 1'b0;
  localparam logic KIND_END = 1'b1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } psf_item_t;

  typedef struct packed {
    logic        record_kind;
    logic [31:0] start_offset;
    logic [15:0] run_length;
    logic [2:0]  ending;
    logic        any_found;
    logic        last_result;
  } psf_record_t;

  // Results of one input transaction: an optional string record and an
  // optional end record, in that order.
  typedef struct packed {
    logic        has_str;
    logic        has_end;
    logic [31:0] start_offset;
    logic [15:0] run_length;
    logic [2:0]  ending;
    logic        any_found;
  } psf_bundle_t;

  typedef struct packed {
    logic full;
    logic not_empty;
  } psf_queue_status_t;

endpackage

@@ hw/rtl/printable_string_finder.sv @@
// Printable string finder: scans a byte stream for printable ASCII runs.
// Input channel: scan_item is taken when push is high and full is low, one
// byte per transaction. Results: a record sits on record while empty is low
// and leaves on a clock edge with pop high. A byte causes no record, a
// string record, an end record (final_byte), or a string then end record;
// last_result marks the last record of that byte.
// Configuration: cfg_data writes min_length when cfg_valid is high; the
// channel is always ready. Write only while the block is idle.
// Throughput: one byte per cycle while the result queue has room; records
// leave at one per cycle while pop is high, so bytes that yield two records
// drain at half rate once the queue fills. The queue depth sets how long
// the back side may stall before full rises.
// Path: a record is written to the result queue when its byte is taken,
// then moved into the back end's hold register, from which it shows on record.
// Reset: min_length returns to 4, the scan state and queue are cleared.
// A stalled receiver fills the queue and then holds off input via full.
module printable_string_finder
  import psf_pkg::*;
#(
  parameter int OFFSET_BITS = OFFSET_BITS_DEFAULT,
  parameter int LENGTH_BITS = LENGTH_BITS_DEFAULT,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data,
  input  logic        push,
  output logic        full,
  input  psf_item_t   scan_item,
  output logic        empty,
  input  logic        pop,
  output psf_record_t record
);

  psf_queue_status_t qstat;
  psf_bundle_t       bundle;
  psf_bundle_t       head;
  logic              bundle_push;
  logic              take;
  logic              accept;

  assign cfg_ready = 1'b1;
  assign full = qstat.full;
  assign accept = push && !qstat.full;

  psf_front #(
    .OFFSET_BITS(OFFSET_BITS),
    .LENGTH_BITS(LENGTH_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .accept     (accept),
    .item       (scan_item),
    .qstat      (qstat),
    .bundle_push(bundle_push),
    .bundle     (bundle)
  );

  psf_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr     (bundle_push),
    .wr_data(bundle),
    .rd     (take),
    .rd_data(head),
    .status (qstat)
  );

  psf_back u_back (
    .clk   (clk),
    .rst   (rst),
    .qstat (qstat),
    .head  (head),
    .take  (take),
    .empty (empty),
    .pop   (pop),
    .record(record)
  );

endmodule

@@ hw/rtl/psf_front.sv @@
module psf_front
  import psf_pkg::*;
#(
  parameter int OFFSET_BITS = OFFSET_BITS_DEFAULT,
  parameter int LENGTH_BITS = LENGTH_BITS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  input  logic [7:0]        cfg_data,
  input  logic              accept,
  input  psf_item_t         item,
  input  psf_queue_status_t qstat,
  output logic              bundle_push,
  output psf_bundle_t       bundle
);

`include "printable_string_finder_defines.svh"

  localparam logic [2:0] MODE_IDLE = 3'd0;
  localparam logic [2:0] MODE_RUN = 3'd1;
  localparam logic [2:0] MODE_LF = 3'd2;
  localparam logic [2:0] MODE_CR = 3'd3;
  localparam logic [2:0] MODE_LFCR = 3'd4;
  localparam logic [2:0] MODE_CRLF = 3'd5;

  logic [7:0]             min_length;
  logic [2:0]             scan_mode;
  logic [2:0]             scan_mode_next;
  logic [OFFSET_BITS-1:0] run_start;
  logic [OFFSET_BITS-1:0] run_start_next;
  logic [LENGTH_BITS-1:0] run_count;
  logic [LENGTH_BITS-1:0] run_count_next;
  logic [OFFSET_BITS-1:0] byte_position;
  logic                   found_flag;

  logic       printable;
  logic       term_hit;
  logic [2:0] term_kind;
  logic       str_hit;
  logic [63:0] start_wide;
  logic [31:0] count_wide;

  assign printable = (item.data_byte >= PRINT_LO) && (item.data_byte <= PRINT_HI);

  always_comb begin
    scan_mode_next = scan_mode;
    run_start_next = run_start;
    run_count_next = run_count;
    term_hit = 1'b0;
    term_kind = END_NUL;
    unique case (scan_mode)
      MODE_RUN: begin
        if (printable) begin
          if (run_count != {LENGTH_BITS{1'b1}}) begin
            run_count_next = run_count + LENGTH_BITS'(1);
          end
        end else if (item.data_byte == CH_NUL) begin
          term_hit = 1'b1;
          term_kind = END_NUL;
        end else if (item.data_byte == CH_LF) begin
          scan_mode_next = MODE_LF;
        end else if (item.data_byte == CH_CR) begin
          scan_mode_next = MODE_CR;
        end else begin
          scan_mode_next = MODE_IDLE;
        end
      end
      MODE_LF, MODE_CR, MODE_LFCR, MODE_CRLF: begin
        if (item.data_byte == CH_NUL) begin
          term_hit = 1'b1;
          unique case (scan_mode)
            MODE_LF:   term_kind = END_LF;
            MODE_CR:   term_kind = END_CR;
            MODE_LFCR: term_kind = END_LFCR;
            default:   term_kind = END_CRLF;
          endcase
        end else if ((scan_mode == MODE_LF) && (item.data_byte == CH_CR)) begin
          scan_mode_next = MODE_LFCR;
        end else if ((scan_mode == MODE_CR) && (item.data_byte == CH_LF)) begin
          scan_mode_next = MODE_CRLF;
        end else if (printable) begin
          run_start_next = byte_position;
          run_count_next = LENGTH_BITS'(1);
          scan_mode_next = MODE_RUN;
        end else begin
          scan_mode_next = MODE_IDLE;
        end
      end
      default: begin
        if (printable) begin
          run_start_next = byte_position;
          run_count_next = LENGTH_BITS'(1);
          scan_mode_next = MODE_RUN;
        end else begin
          scan_mode_next = MODE_IDLE;
        end
      end
    endcase
    if (term_hit) begin
      scan_mode_next = MODE_IDLE;
    end
  end

  assign str_hit = term_hit && (run_count >= LENGTH_BITS'(min_length));
  assign start_wide = 64'(run_start);
  assign count_wide = 32'(run_count);

  assign bundle_push = accept && (str_hit || item.final_byte);

  always_comb begin
    bundle.has_str = str_hit;
    bundle.has_end = item.final_byte;
    bundle.start_offset = start_wide[31:0];
    bundle.run_length = count_wide[15:0];
    bundle.ending = term_kind;
    bundle.any_found = found_flag || str_hit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_length <= MIN_LENGTH_RESET;
    end else if (cfg_valid) begin
      min_length <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode <= MODE_IDLE;
      run_start <= '0;
      run_count <= '0;
      byte_position <= '0;
      found_flag <= 1'b0;
    end else if (accept) begin
      if (item.final_byte) begin
        scan_mode <= MODE_IDLE;
        run_start <= '0;
        run_count <= '0;
        byte_position <= '0;
        found_flag <= 1'b0;
      end else begin
        scan_mode <= scan_mode_next;
        run_start <= run_start_next;
        run_count <= run_count_next;
        byte_position <= byte_position + OFFSET_BITS'(1);
        found_flag <= found_flag || str_hit;
      end
    end
  end

  `PSF_ASSERT_NEXT(a_final_clears, clk, rst, accept && item.final_byte,
    (scan_mode == MODE_IDLE) && (byte_position == '0) && !found_flag,
    "scan state not cleared after final byte")
  `PSF_ASSERT_NOW(a_push_has_room, clk, rst, bundle_push, !qstat.full,
    "bundle pushed into full queue")
  `PSF_ASSERT_NOW(a_run_nonzero, clk, rst, scan_mode == MODE_RUN, run_count != '0,
    "open run with zero length")

endmodule

@@ hw/rtl/psf_queue.sv @@
module psf_queue
  import psf_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr,
  input  psf_bundle_t       wr_data,
  input  logic              rd,
  output psf_bundle_t       rd_data,
  output psf_queue_status_t status
);

`include "printable_string_finder_defines.svh"

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  psf_bundle_t         store [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] count;

  assign status.full = (count == CNT_BITS'(DEPTH));
  assign status.not_empty = (count != '0);
  assign rd_data = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      store[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr + PTR_BITS'(1);
      end
      if (rd) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr + PTR_BITS'(1);
      end
      if (wr && !rd) begin
        count <= count + CNT_BITS'(1);
      end else if (rd && !wr) begin
        count <= count - CNT_BITS'(1);
      end
    end
  end

  `PSF_ASSERT_NOW(a_no_overflow, clk, rst, wr && !rd, !status.full,
    "queue write while full")
  `PSF_ASSERT_NOW(a_no_underflow, clk, rst, rd, status.not_empty,
    "queue read while empty")
  `PSF_ASSERT_NOW(a_count_bound, clk, rst, 1'b1, count <= CNT_BITS'(DEPTH),
    "queue count beyond depth")

endmodule

@@ hw/rtl/psf_back.sv @@
module psf_back
  import psf_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  psf_queue_status_t qstat,
  input  psf_bundle_t       head,
  output logic              take,
  output logic              empty,
  input  logic              pop,
  output psf_record_t       record
);

`include "printable_string_finder_defines.svh"

  psf_bundle_t hold;
  logic        hold_valid;
  logic        phase;
  logic        show_str;
  logic        done;

  assign show_str = hold.has_str && !phase;
  assign empty = !hold_valid;
  assign done = pop && hold_valid && !(show_str && hold.has_end);
  assign take = qstat.not_empty && (!hold_valid || done);

  always_comb begin
    if (show_str) begin
      record.record_kind = KIND_STRING;
      record.start_offset = hold.start_offset;
      record.run_length = hold.run_length;
      record.ending = hold.ending;
      record.any_found = 1'b0;
      record.last_result = !hold.has_end;
    end else begin
      record.record_kind = KIND_END;
      record.start_offset = '0;
      record.run_length = '0;
      record.ending = END_NUL;
      record.any_found = hold.any_found;
      record.last_result = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      hold <= head;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      phase <= 1'b0;
    end else if (take) begin
      hold_valid <= 1'b1;
      phase <= 1'b0;
    end else if (done) begin
      hold_valid <= 1'b0;
      phase <= 1'b0;
    end else if (pop && hold_valid) begin
      phase <= 1'b1;
    end
  end

  `PSF_ASSERT_NOW(a_phase_end, clk, rst, hold_valid && phase, hold.has_end && hold.has_str,
    "second record without end record")
  `PSF_ASSERT_NOW(a_bundle_nonempty, clk, rst, hold_valid, hold.has_str || hold.has_end,
    "empty bundle held")
  `PSF_ASSERT_NEXT(a_split_order, clk, rst, pop && hold_valid && show_str && hold.has_end,
    hold_valid && phase, "end record skipped")

endmodule
